### src/mafhd_pkg.sv
// Package for the MPEG audio / ADTS frame header decoder.
// Holds payload structs, status codes, lookup tables and queue entry type.
// No dependencies.
`default_nettype none

package mafhd_pkg;

  localparam int NUMER_W = 26;
  localparam int RATE_W  = 17;
  localparam int LEN_W   = 13;
  localparam int CFG_IDX_W = 2;

  typedef struct packed {
    logic [55:0] header_bytes;
    logic [15:0] bytes_available;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [LEN_W-1:0]  frame_length;
    logic [3:0]        header_length;
    logic [12:0]       frame_samples;
    logic [RATE_W-1:0] sample_rate;
    logic              rate_changed;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MORE    = 2'd1,
    ST_INVALID = 2'd2,
    ST_NOSYNC  = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STREAM_KIND = 2'd0,
    CFG_SYNC_MASK   = 2'd1,
    CFG_SYNC_MATCH  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic        stream_kind;
    logic [31:0] sync_mask;
    logic [31:0] sync_match;
  } cfg_t;

  typedef enum logic [1:0] {
    KIND_NOSYNC = 2'd0,
    KIND_ADTS   = 2'd1,
    KIND_MPEG   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_DIV  = 2'd1,
    BK_FIN  = 2'd2
  } bk_state_t;

  // classified header, front to back
  typedef struct packed {
    kind_t              kind;
    logic               need_div;
    logic               layer1;
    logic               pad;
    logic [NUMER_W-1:0] numer;
    logic [RATE_W-1:0]  rate;
    logic [LEN_W-1:0]   adts_len;
    logic [3:0]         hlen;
    logic [12:0]        samples;
    logic [15:0]        avail;
  } entry_t;

  localparam logic [1:0] LAYER_I   = 2'd3;
  localparam logic [1:0] LAYER_II  = 2'd2;
  localparam logic [1:0] LAYER_III = 2'd1;
  localparam logic [1:0] VER_1     = 2'd3;

  localparam logic [8:0] BR_V1_L1 [16] = '{
    9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
    9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0};
  localparam logic [8:0] BR_V1_L2 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0};
  localparam logic [8:0] BR_V1_L3 [16] = '{
    9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
    9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0};
  localparam logic [8:0] BR_V2_L1 [16] = '{
    9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
    9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0};
  localparam logic [8:0] BR_V2_L23 [16] = '{
    9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
    9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0};

  localparam logic [RATE_W-1:0] ADTS_RATES [16] = '{
    17'd96000, 17'd88200, 17'd64000, 17'd48000, 17'd44100, 17'd32000,
    17'd24000, 17'd22050, 17'd16000, 17'd12000, 17'd11025, 17'd8000,
    17'd0, 17'd0, 17'd0, 17'd0};

  // index {rate code, version}
  localparam logic [RATE_W-1:0] MPA_RATES [16] = '{
    17'd11025, 17'd0, 17'd22050, 17'd44100,
    17'd12000, 17'd0, 17'd24000, 17'd48000,
    17'd8000,  17'd0, 17'd16000, 17'd32000,
    17'd0,     17'd0, 17'd0,     17'd0};

  // index {version, layer code}
  localparam logic [12:0] MPA_SAMPLES [16] = '{
    13'd0, 13'd576,  13'd1152, 13'd384,
    13'd0, 13'd0,    13'd0,    13'd0,
    13'd0, 13'd576,  13'd1152, 13'd384,
    13'd0, 13'd1152, 13'd1152, 13'd384};

  function automatic logic [8:0] mpa_kbps(input logic [1:0] ver, input logic [1:0] layer,
                                          input logic [3:0] code);
    logic [8:0] k;
    k = 9'd0;
    if (ver == VER_1) begin
      case (layer)
        LAYER_I:   k = BR_V1_L1[code];
        LAYER_II:  k = BR_V1_L2[code];
        LAYER_III: k = BR_V1_L3[code];
        default:   k = 9'd0;
      endcase
    end else if (layer == LAYER_I) begin
      k = BR_V2_L1[code];
    end else begin
      k = BR_V2_L23[code];
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### src/mafhd_front.sv
// Front end: sync check and header classification into a queue entry.
// Depends on mafhd_pkg (tables, entry_t).
`default_nettype none

module mafhd_front import mafhd_pkg::*; (
  input  in_item_t in_data,
  input  cfg_t     cfg,
  output entry_t   entry
);

  logic [31:0] first;
  logic [7:0]  b1, b2, b3, b4, b5, b6;
  logic        nosync;
  logic [1:0]  ver, layer;
  logic [8:0]  kbps;
  logic [RATE_W-1:0] mrate;
  logic [12:0] msamples;
  logic [17:0] coef;
  logic [26:0] prod;
  logic [2:0]  blocks;

  always_comb begin
    first = in_data.header_bytes[55:24];
    b1 = in_data.header_bytes[47:40];
    b2 = in_data.header_bytes[39:32];
    b3 = in_data.header_bytes[31:24];
    b4 = in_data.header_bytes[23:16];
    b5 = in_data.header_bytes[15:8];
    b6 = in_data.header_bytes[7:0];
    nosync = (cfg.sync_mask == 32'd0) || ((first & cfg.sync_mask) != cfg.sync_match);

    ver      = b1[4:3];
    layer    = b1[2:1];
    kbps     = mpa_kbps(ver, layer, b2[7:4]);
    mrate    = MPA_RATES[{b2[3:2], ver}];
    msamples = MPA_SAMPLES[{ver, layer}];
    if (layer == LAYER_I)         coef = 18'd12000;
    else if (msamples == 13'd1152) coef = 18'd144000;
    else                          coef = 18'd72000;
    prod   = {18'd0, kbps} * {9'd0, coef};
    blocks = {1'b0, b6[1:0]} + 3'd1;

    entry.avail    = in_data.bytes_available;
    entry.adts_len = {b3[1:0], b4, b5[7:5]};
    entry.numer    = prod[NUMER_W-1:0];
    entry.pad      = b2[1];
    entry.layer1   = (layer == LAYER_I);
    if (nosync) begin
      entry.kind     = KIND_NOSYNC;
      entry.need_div = 1'b0;
      entry.rate     = '0;
      entry.hlen     = 4'd0;
      entry.samples  = 13'd0;
    end else if (cfg.stream_kind) begin
      entry.kind     = KIND_ADTS;
      entry.need_div = 1'b0;
      entry.rate     = ADTS_RATES[b2[5:2]];
      entry.hlen     = b1[0] ? 4'd7 : 4'd9;
      entry.samples  = {blocks, 10'd0};
    end else begin
      entry.kind     = KIND_MPEG;
      entry.need_div = (mrate != '0) && (kbps != 9'd0) && (msamples != 13'd0);
      entry.rate     = mrate;
      entry.hlen     = b1[0] ? 4'd4 : 4'd6;
      entry.samples  = msamples;
    end
  end

endmodule

`default_nettype wire

### src/mafhd_fifo.sv
// Two-entry queue of classified headers between front and back.
// Depends on mafhd_pkg (entry_t).
`default_nettype none

module mafhd_fifo import mafhd_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t wr_entry,
  output logic   full,
  input  logic   pop,
  output logic   not_empty,
  output entry_t rd_entry
);

  entry_t     mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  always_comb begin
    full       = (count_r == 2'd2);
    not_empty  = (count_r != 2'd0);
    rd_entry   = mem_r[rd_ptr_r];
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_entry;
  end

endmodule

`default_nettype wire

### src/mafhd_back.sv
// Back end: serial length divide, status, sample rate tracking, result register.
// Depends on mafhd_pkg (entry_t, out_item_t, bk_state_t).
`default_nettype none

module mafhd_back import mafhd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_not_empty,
  input  entry_t    q_entry,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(NUMER_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUMER_W - 1);

  bk_state_t          state_r, state_nxt;
  entry_t             e_r;
  logic [NUMER_W-1:0] quo_r, quo_nxt;
  logic [RATE_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [RATE_W-1:0]  cur_rate_r, cur_rate_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;

  logic [RATE_W:0]    rem_sh, rem_sub;
  logic               ge;
  logic [LEN_W-1:0]   q_pad, calc_len, len;
  status_t            st;
  logic               upd;

  always_comb begin
    rem_sh  = {rem_r, quo_r[NUMER_W-1]};
    ge      = (rem_sh >= {1'b0, e_r.rate});
    rem_sub = rem_sh - {1'b0, e_r.rate};

    q_pad    = quo_r[LEN_W-1:0] + {{(LEN_W-1){1'b0}}, e_r.pad};
    calc_len = e_r.layer1 ? {q_pad[LEN_W-3:0], 2'b00} : q_pad;
    if (e_r.kind == KIND_ADTS) len = e_r.adts_len;
    else if (e_r.need_div)     len = calc_len;
    else                       len = '0;

    if (e_r.kind == KIND_NOSYNC)            st = ST_NOSYNC;
    else if (len == '0)                     st = ST_INVALID;
    else if (e_r.avail < {3'd0, len})       st = ST_MORE;
    else                                    st = ST_OK;

    case (e_r.kind)
      KIND_MPEG: upd = (e_r.rate != '0) && (e_r.rate != cur_rate_r);
      KIND_ADTS: upd = (st == ST_OK) && (e_r.rate != cur_rate_r);
      default:   upd = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    cur_rate_nxt  = cur_rate_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      BK_IDLE: begin
        if (q_not_empty && (!out_valid_r || !out_stall)) begin
          q_pop     = 1'b1;
          quo_nxt   = q_entry.numer;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = q_entry.need_div ? BK_DIV : BK_FIN;
        end
      end
      BK_DIV: begin
        quo_nxt = {quo_r[NUMER_W-2:0], ge};
        rem_nxt = ge ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) state_nxt = BK_FIN;
      end
      BK_FIN: begin
        out_valid_nxt         = 1'b1;
        out_nxt.status        = st;
        out_nxt.frame_length  = (st == ST_OK) ? len : '0;
        out_nxt.header_length = e_r.hlen;
        out_nxt.frame_samples = e_r.samples;
        out_nxt.sample_rate   = e_r.rate;
        out_nxt.rate_changed  = upd;
        if (upd) cur_rate_nxt = e_r.rate;
        state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      cur_rate_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_rate_r  <= cur_rate_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) e_r <= q_entry;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

### src/mpeg_audio_frame_header_decode.sv
// Top level of the MPEG audio / ADTS frame header decoder.
// Depends on mafhd_pkg, mafhd_front, mafhd_fifo, mafhd_back.
//
//   channel | ports                          | direction
//   --------+--------------------------------+----------
//   in      | in_valid, in_stall, in_data    | request in
//   out     | out_valid, out_stall, out_data | request out
//   cfg     | cfg_wr_en, cfg_index, cfg_wdata| write only
//
// In the back end, an MPEG request with a computable length runs through the
// 26-step restoring divider (one quotient bit per cycle); others go from idle
// straight to the finish state. A two-entry queue decouples front and back.
// Synchronous active-low reset clears config, stored rate and the queue.
// in_stall rises only when the queue is full; out_stall holds the result.
`default_nettype none

module mpeg_audio_frame_header_decode import mafhd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  cfg_t   cfg_r, cfg_nxt;
  entry_t f_entry, q_entry;
  logic   q_full, q_not_empty, q_pop, push;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STREAM_KIND: cfg_nxt.stream_kind = cfg_wdata[0];
        CFG_SYNC_MASK:   cfg_nxt.sync_mask   = cfg_wdata;
        CFG_SYNC_MATCH:  cfg_nxt.sync_match  = cfg_wdata;
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= '0;
    else        cfg_r <= cfg_nxt;
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  mafhd_front u_front (
    .in_data (in_data),
    .cfg     (cfg_r),
    .entry   (f_entry)
  );

  mafhd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_entry  (f_entry),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .rd_entry  (q_entry)
  );

  mafhd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_entry     (q_entry),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for mpeg_audio_frame_header_decode: MPEG audio and ADTS header requests.
// Holds its own header decoder as predictor, with a driver and a monitor on the valid/stall ports.
// Depends on mafhd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb;
  import mafhd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned LONG_HOLD    = 300;

  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  localparam logic [1:0] VER_25     = 2'd0;
  localparam logic [1:0] VER_RSVD   = 2'd1;
  localparam logic [1:0] VER_2      = 2'd2;
  localparam logic [1:0] LAYER_RSVD = 2'd0;

  localparam logic [1:0] RC_44K1 = 2'd0;
  localparam logic [1:0] RC_48K  = 2'd1;
  localparam logic [1:0] RC_32K  = 2'd2;
  localparam logic [1:0] RC_RSVD = 2'd3;

  localparam int unsigned MPA_BASE_HZ [4] = '{44100, 48000, 32000, 0};

  localparam int unsigned ADTS_HZ [16] = '{
    96000, 88200, 64000, 48000, 44100, 32000, 24000, 22050,
    16000, 12000, 11025, 8000, 0, 0, 0, 0};

  // rows: v1 L1, v1 L2, v1 L3, v2 L1, v2 L2/L3
  localparam int unsigned KBPS [5][16] = '{
    '{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 0},
    '{0, 32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160, 0}};

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_stall;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_wdata = '0;

  // mirrored block state
  logic        lock_kind  = 1'b0;
  logic [31:0] lock_mask  = '0;
  logic [31:0] lock_match = '0;
  logic [16:0] rate_held  = '0;

  in_item_t    req_queue[$];
  out_item_t   exp_results[$];

  logic        send_idle      = 1'b1;
  logic        recv_idle      = 1'b1;
  logic        long_hold_req  = 1'b0;
  logic        long_hold_done = 1'b0;
  int unsigned gap_left       = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatches     = 0;
  int unsigned rate_changes   = 0;
  int unsigned settings_used  = 0;
  int unsigned status_tally [4] = '{0, 0, 0, 0};

  mpeg_audio_frame_header_decode i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int unsigned mpa_hz(input logic [1:0] ver, input logic [1:0] rc);
    int unsigned hz;
    hz = 0;
    if (ver == VER_1) hz = MPA_BASE_HZ[rc];
    else if (ver == VER_2) hz = MPA_BASE_HZ[rc] / 2;
    else if (ver == VER_25) hz = MPA_BASE_HZ[rc] / 4;
    return hz;
  endfunction

  function automatic int unsigned mpa_spf(input logic [1:0] ver, input logic [1:0] layer);
    int unsigned spf;
    if (ver == VER_RSVD || layer == LAYER_RSVD) spf = 0;
    else if (layer == LAYER_I) spf = 384;
    else if (layer == LAYER_II || ver == VER_1) spf = 1152;
    else spf = 576;
    return spf;
  endfunction

  // frame bytes of an MPEG header, 0 when not computable
  function automatic int unsigned mpa_len_of(input logic [55:0] h);
    logic [1:0]      ver;
    logic [1:0]      layer;
    int unsigned     hz;
    int unsigned     spf;
    int unsigned     kbps;
    int unsigned     row;
    longint unsigned bps;
    longint unsigned n;
    ver   = h[44:43];
    layer = h[42:41];
    hz    = mpa_hz(ver, h[35:34]);
    spf   = mpa_spf(ver, layer);
    if (ver == VER_1) row = (layer == LAYER_I) ? 0 : (layer == LAYER_II) ? 1 : 2;
    else row = (layer == LAYER_I) ? 3 : 4;
    kbps = KBPS[row][h[39:36]];
    n = 0;
    if (hz != 0 && kbps != 0 && spf != 0) begin
      bps = longint'(kbps) * 1000;
      if (layer == LAYER_I) n = (12 * bps / hz + h[33]) * 4;
      else n = longint'(spf / 8) * bps / hz + h[33];
    end
    return int'(n);
  endfunction

  function automatic out_item_t decode_header(input in_item_t req);
    out_item_t   r;
    logic [55:0] h;
    logic [12:0] adts_len;
    int unsigned flen;
    h = req.header_bytes;
    r = '0;
    if (lock_mask == 0 || (h[55:24] & lock_mask) != lock_match) begin
      r.status = ST_NOSYNC;
    end else if (lock_kind) begin
      adts_len        = h[25:13];
      r.sample_rate   = 17'(ADTS_HZ[h[37:34]]);
      r.header_length = h[40] ? 4'd7 : 4'd9;
      r.frame_samples = 13'(({11'd0, h[1:0]} + 13'd1) << 10);
      if (adts_len == 0) begin
        r.status = ST_INVALID;
      end else if (req.bytes_available < adts_len) begin
        r.status = ST_MORE;
      end else begin
        r.status       = ST_OK;
        r.frame_length = adts_len;
        if (r.sample_rate != rate_held) begin
          rate_held      = r.sample_rate;
          r.rate_changed = 1'b1;
        end
      end
    end else begin
      r.sample_rate   = 17'(mpa_hz(h[44:43], h[35:34]));
      r.frame_samples = 13'(mpa_spf(h[44:43], h[42:41]));
      r.header_length = h[40] ? 4'd4 : 4'd6;
      if (r.sample_rate == 0) begin
        r.status = ST_INVALID;
      end else begin
        // rate is taken before the length is judged
        if (r.sample_rate != rate_held) begin
          rate_held      = r.sample_rate;
          r.rate_changed = 1'b1;
        end
        flen = mpa_len_of(h);
        if (flen == 0) begin
          r.status = ST_INVALID;
        end else if (req.bytes_available < flen) begin
          r.status = ST_MORE;
        end else begin
          r.status       = ST_OK;
          r.frame_length = 13'(flen);
        end
      end
    end
    return r;
  endfunction

  function automatic logic [55:0] mpa_hdr(input logic [1:0] ver, input logic [1:0] layer,
                                          input logic prot, input logic [3:0] br,
                                          input logic [1:0] rc, input logic pad);
    return {8'hFF, 3'b111, ver, layer, prot, br, rc, pad, 1'b0, 8'h44, 24'h0};
  endfunction

  function automatic logic [55:0] adts_hdr(input logic prot, input logic [3:0] ri,
                                           input logic [12:0] flen, input logic [1:0] blk);
    logic [55:0] h;
    h = {8'hFF, 4'hF, 1'b0, 2'b00, prot, 2'b01, ri, 2'b00, 32'h0000_1FFC};
    h[25:13] = flen;
    h[1:0]   = blk;
    return h;
  endfunction

  function automatic in_item_t make_request();
    logic [55:0] h;
    logic [15:0] avail;
    int unsigned flen;
    int unsigned pick;
    h[55:24] = $urandom;
    h[23:0]  = 24'($urandom);
    if ($urandom_range(99, 0) < 15) return in_item_t'{header_bytes: h, bytes_available: 16'($urandom)};
    if (lock_kind) begin
      pick = $urandom_range(9, 0);
      if (pick == 0) h[25:13] = '0;
      else if (pick == 1) h[25:13] = '1;
      else if (pick < 8) h[25:13] = 13'($urandom_range(2000, 1));
    end
    h[55:24] = (h[55:24] & ~lock_mask) | (lock_match & lock_mask);
    flen = lock_kind ? int'(h[25:13]) : mpa_len_of(h);
    pick = $urandom_range(9, 0);
    case (pick)
      0:       avail = '0;
      1:       avail = '1;
      2, 3:    avail = 16'($urandom);
      4, 5, 6: avail = 16'(flen + $urandom_range(2, 0));
      default: avail = (flen > 3) ? 16'(flen - $urandom_range(3, 1)) : '0;
    endcase
    return in_item_t'{header_bytes: h, bytes_available: avail};
  endfunction

  function automatic void queue_req(input logic [55:0] h, input logic [15:0] avail);
    req_queue.push_back(in_item_t'{header_bytes: h, bytes_available: avail});
  endfunction

  function automatic void cmp_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_result(input out_item_t got);
    out_item_t want;
    if (exp_results.size() == 0) begin
      $error("result with no request pending, status %0d", got.status);
      mismatches++;
    end else begin
      want = exp_results.pop_front();
      cmp_field("status", want.status, got.status);
      cmp_field("frame_length", want.frame_length, got.frame_length);
      cmp_field("header_length", want.header_length, got.header_length);
      cmp_field("frame_samples", want.frame_samples, got.frame_samples);
      cmp_field("sample_rate", want.sample_rate, got.sample_rate);
      cmp_field("rate_changed", want.rate_changed, got.rate_changed);
      status_tally[got.status]++;
      if (got.rate_changed) rate_changes++;
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) exp_results.push_back(decode_header(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          in_valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (req_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_data  <= req_queue.pop_front();
          gap_left <= send_idle ? $urandom_range(6, 0) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : result_check
    int unsigned hold_next;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (out_valid && !out_stall) check_result(out_data);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        out_stall      <= 1'b1;
        hold_left      <= LONG_HOLD;
      end else if (out_valid && !out_stall) begin
        hold_next = recv_idle ? $urandom_range(6, 0) : 0;
        out_stall <= (hold_next != 0);
        hold_left <= hold_next;
      end else if (out_stall) begin
        if (hold_left <= 1) out_stall <= 1'b0;
        hold_left <= hold_left - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               exp_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic settle();
    while (req_queue.size() != 0 || in_valid || exp_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // the write to the unused index must be ignored
  task automatic write_regs(input logic kind, input logic [31:0] mask, input logic [31:0] match);
    logic [31:0] junk;
    junk = $urandom;
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_STREAM_KIND;
    cfg_wdata <= {junk[31:1], kind};
    @(posedge clk);
    cfg_index <= CFG_SYNC_MASK;
    cfg_wdata <= mask;
    @(posedge clk);
    cfg_index <= CFG_SYNC_MATCH;
    cfg_wdata <= match;
    @(posedge clk);
    cfg_index <= CFG_NO_REG;
    cfg_wdata <= ~junk;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    lock_kind  = kind;
    lock_mask  = mask;
    lock_match = match;
    @(negedge clk);
  endtask

  task automatic run_phase(input logic kind, input logic [31:0] mask, input logic [31:0] match,
                           input int unsigned n, input logic s_idle, input logic r_idle);
    settle();
    write_regs(kind, mask, match);
    send_idle = s_idle;
    recv_idle = r_idle;
    settings_used++;
    repeat (n) req_queue.push_back(make_request());
  endtask

  initial begin : stimulus
    logic [1:0]  v;
    logic [1:0]  l;
    logic [31:0] m;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // not locked out of reset
    queue_req('1, 16'hFFFF);
    queue_req('0, 16'h0000);

    run_phase(1'b0, 32'hFFE0_0000, 32'hFFE0_0000, 0, 1'b1, 1'b1);
    queue_req(mpa_hdr(VER_1, LAYER_III, 1'b1, 4'd9, RC_44K1, 1'b0), 16'hFFFF);
    queue_req(mpa_hdr(VER_1, LAYER_III, 1'b1, 4'd9, RC_44K1, 1'b1), 16'd418);
    queue_req(mpa_hdr(VER_1, LAYER_I, 1'b0, 4'd2, RC_44K1, 1'b1), 16'd71);
    queue_req(mpa_hdr(VER_1, LAYER_II, 1'b1, 4'd14, RC_48K, 1'b0), 16'd1152);
    queue_req(mpa_hdr(VER_1, LAYER_I, 1'b1, 4'd14, RC_32K, 1'b0), 16'd672);
    queue_req(mpa_hdr(VER_2, LAYER_I, 1'b1, 4'd9, RC_48K, 1'b0), 16'd288);
    queue_req(mpa_hdr(VER_25, LAYER_III, 1'b1, 4'd14, RC_32K, 1'b0), 16'd1440);
    queue_req(mpa_hdr(VER_25, LAYER_II, 1'b1, 4'd14, RC_32K, 1'b1), 16'd2881);
    queue_req(mpa_hdr(VER_1, LAYER_III, 1'b1, 4'd0, RC_44K1, 1'b0), 16'hFFFF);
    queue_req(mpa_hdr(VER_1, LAYER_III, 1'b1, 4'd15, RC_44K1, 1'b0), 16'hFFFF);
    queue_req(mpa_hdr(VER_1, LAYER_III, 1'b1, 4'd9, RC_RSVD, 1'b0), 16'hFFFF);
    queue_req(mpa_hdr(VER_1, LAYER_RSVD, 1'b1, 4'd9, RC_48K, 1'b0), 16'hFFFF);
    queue_req(mpa_hdr(VER_RSVD, LAYER_III, 1'b1, 4'd9, RC_44K1, 1'b0), 16'hFFFF);
    queue_req(mpa_hdr(VER_2, LAYER_III, 1'b1, 4'd5, RC_32K, 1'b0), 16'd0);
    queue_req(56'h00_1234_5678_9ABC, 16'hFFFF);

    run_phase(1'b1, 32'hFFF0_0000, 32'hFFF0_0000, 0, 1'b1, 1'b1);
    queue_req(adts_hdr(1'b1, 4'd3, 13'd0, 2'd0), 16'hFFFF);
    queue_req(adts_hdr(1'b1, 4'd12, 13'd100, 2'd0), 16'd100);
    queue_req(adts_hdr(1'b0, 4'd0, 13'd8191, 2'd3), 16'hFFFF);
    queue_req(adts_hdr(1'b1, 4'd11, 13'd50, 2'd1), 16'd49);
    queue_req(adts_hdr(1'b1, 4'd11, 13'd7, 2'd2), 16'd7);
    queue_req('1, 16'hFFFF);

    run_phase(1'b0, 32'hFFE0_0000, 32'hFFE0_0000, 62, 1'b1, 1'b1);

    // version and layer pinned by the sync pattern; receiver holds off a while
    v = 2'($urandom_range(2, 0));
    if (v == VER_RSVD) v = VER_1;
    l = 2'($urandom_range(3, 1));
    run_phase(1'b0, 32'hFFFE_0000, {8'hFF, 3'b111, v, l, 1'b0, 16'h0}, 62, 1'b0, 1'b1);
    long_hold_req = 1'b1;

    run_phase(1'b1, 32'hFFF6_0000, 32'hFFF0_0000, 62, 1'($urandom), 1'($urandom));

    v = 2'($urandom_range(2, 0));
    if (v == VER_RSVD) v = VER_2;
    l = 2'($urandom_range(3, 1));
    m = {8'hFF, 3'b111, v, l, 1'($urandom), 4'($urandom_range(14, 1)),
         2'($urandom_range(2, 0)), 1'($urandom), 1'b0, 8'($urandom)};
    run_phase(1'b0, 32'hFFFF_FFFF, m, 62, 1'($urandom), 1'($urandom));

    run_phase(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 62, 1'($urandom), 1'($urandom));
    run_phase(1'b0, 32'h0000_0001, 32'h0000_0000, 62, 1'b1, 1'b1);
    run_phase(1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 20, 1'b1, 1'b1);
    // match bits outside the mask can never be met
    run_phase(1'b1, 32'hFFF0_0000, 32'hFFF0_0001, 20, 1'b1, 1'b0);
    run_phase(1'b0, 32'hFFE0_0000, 32'hFFE0_0000, 62, 1'b0, 1'b0);
    run_phase(1'b1, 32'hFFF0_0000, 32'hFFF0_0000, 62, 1'b1, 1'b1);

    settle();
    $display("%0d headers over %0d register settings: %0d ok, %0d short, %0d invalid, %0d no sync",
             status_tally[ST_OK] + status_tally[ST_MORE] + status_tally[ST_INVALID] +
             status_tally[ST_NOSYNC], settings_used, status_tally[ST_OK],
             status_tally[ST_MORE], status_tally[ST_INVALID], status_tally[ST_NOSYNC]);
    $display("%0d sample rate changes, one %0d-cycle output hold", rate_changes, LONG_HOLD);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### mpeg_audio_frame_header_decode.f
src/mafhd_pkg.sv
src/mafhd_front.sv
src/mafhd_fifo.sv
src/mafhd_back.sv
src/mpeg_audio_frame_header_decode.sv
bench/tb.sv
